@@ rtl/core/segi_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// segi_pkg
// shared widths, status codes, queue entry and divider step for the
// segment intersection block
// ---------------------------------------------------------------------------
package segi_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int T_FRAC_BITS = 16;

	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int T_W     = T_FRAC_BITS + 1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

	typedef enum logic [1:0] {
		ST_CROSS    = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_OUTSIDE  = 2'd2
	} segi_status_t;

	// classified item handed from the front to the back
	typedef struct packed {
		segi_status_t       status;
		logic               t_one;
		logic [CROSS_W-1:0] tn;
		logic [CROSS_W-1:0] den;
	} segi_entry_t;

	// one stage of the restoring divider
	typedef struct packed {
		segi_status_t           status;
		logic                   t_one;
		logic [CROSS_W-1:0]     den;
		logic [CROSS_W-1:0]     rem;
		logic [T_FRAC_BITS-1:0] quo;
	} segi_div_t;

	// one quotient bit: shift the remainder, subtract when it fits
	function automatic segi_div_t segi_div_step(segi_div_t d);
		logic [CROSS_W:0] shifted;
		logic [CROSS_W:0] diff;
		segi_div_t        r;
		shifted = {d.rem, 1'b0};
		diff    = shifted - {1'b0, d.den};
		r       = d;
		if (shifted >= {1'b0, d.den}) begin
			r.rem = diff[CROSS_W-1:0];
			r.quo = {d.quo[T_FRAC_BITS-2:0], 1'b1};
		end else begin
			r.rem = shifted[CROSS_W-1:0];
			r.quo = {d.quo[T_FRAC_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/segi_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// segi_front
// accepts segment pairs, forms the cross products and classifies the pair
// ---------------------------------------------------------------------------
module segi_front
	import segi_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          seg_valid,
	output logic                               seg_ready,
	input  wire logic signed [COORD_WIDTH-1:0] p_start_x,
	input  wire logic signed [COORD_WIDTH-1:0] p_start_y,
	input  wire logic signed [COORD_WIDTH-1:0] p_end_x,
	input  wire logic signed [COORD_WIDTH-1:0] p_end_y,
	input  wire logic signed [COORD_WIDTH-1:0] q_start_x,
	input  wire logic signed [COORD_WIDTH-1:0] q_start_y,
	input  wire logic signed [COORD_WIDTH-1:0] q_end_x,
	input  wire logic signed [COORD_WIDTH-1:0] q_end_y,
	output logic                               push_valid,
	input  wire logic                          push_ready,
	output segi_entry_t                        push_data
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [DIFF_W-1:0]  rx_s1, ry_s1, sx_s1, sy_s1, dx_s1, dy_s1;
	logic signed [PROD_W-1:0]  rxsy_s2, rysx_s2, dxsy_s2, dysx_s2, dxry_s2, dyrx_s2;
	logic signed [CROSS_W-1:0] den_s3, tn_s3, un_s3;
	logic signed [CROSS_W-1:0] den_s4, tn_s4, un_s4;
	logic                      zero_s4;
	segi_entry_t               ent_s5;

	logic outside;

	// whole front stalls only when its last stage cannot enter the queue
	assign en         = !v_s5 || push_ready;
	assign seg_ready  = en;
	assign push_valid = v_s5;
	assign push_data  = ent_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= seg_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		outside = tn_s4[CROSS_W-1] || un_s4[CROSS_W-1] || (tn_s4 > den_s4) || (un_s4 > den_s4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// edge vectors at full width
			rx_s1 <= DIFF_W'(p_end_x) - DIFF_W'(p_start_x);
			ry_s1 <= DIFF_W'(p_end_y) - DIFF_W'(p_start_y);
			sx_s1 <= DIFF_W'(q_end_x) - DIFF_W'(q_start_x);
			sy_s1 <= DIFF_W'(q_end_y) - DIFF_W'(q_start_y);
			dx_s1 <= DIFF_W'(q_start_x) - DIFF_W'(p_start_x);
			dy_s1 <= DIFF_W'(q_start_y) - DIFF_W'(p_start_y);

			rxsy_s2 <= rx_s1 * sy_s1;
			rysx_s2 <= ry_s1 * sx_s1;
			dxsy_s2 <= dx_s1 * sy_s1;
			dysx_s2 <= dy_s1 * sx_s1;
			dxry_s2 <= dx_s1 * ry_s1;
			dyrx_s2 <= dy_s1 * rx_s1;

			den_s3 <= CROSS_W'(rxsy_s2) - CROSS_W'(rysx_s2);
			tn_s3  <= CROSS_W'(dxsy_s2) - CROSS_W'(dysx_s2);
			un_s3  <= CROSS_W'(dxry_s2) - CROSS_W'(dyrx_s2);

			// make the denominator positive
			zero_s4 <= (den_s3 == '0);
			if (den_s3[CROSS_W-1]) begin
				den_s4 <= -den_s3;
				tn_s4  <= -tn_s3;
				un_s4  <= -un_s3;
			end else begin
				den_s4 <= den_s3;
				tn_s4  <= tn_s3;
				un_s4  <= un_s3;
			end

			if (zero_s4) begin
				ent_s5.status <= ST_PARALLEL;
			end else if (outside) begin
				ent_s5.status <= ST_OUTSIDE;
			end else begin
				ent_s5.status <= ST_CROSS;
			end
			ent_s5.t_one <= (tn_s4 == den_s4);
			ent_s5.tn    <= tn_s4;
			ent_s5.den   <= den_s4;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/segi_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// segi_queue
// short fifo of classified items between front and back
// ---------------------------------------------------------------------------
module segi_queue
	import segi_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire segi_entry_t  push_data,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output segi_entry_t       pop_data
);

	segi_entry_t       mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push, pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/segi_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// segi_back
// pipelined restoring divider for t and the result register
// ---------------------------------------------------------------------------
module segi_back
	import segi_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         pop_valid,
	output logic              pop_ready,
	input  wire segi_entry_t  pop_data,
	output logic              res_valid,
	input  wire logic         res_ready,
	output logic [1:0]        status,
	output logic [T_W-1:0]    t_frac
);

	logic             en;
	logic             v_s [T_FRAC_BITS];
	segi_div_t        div_s [T_FRAC_BITS];
	segi_div_t        step [T_FRAC_BITS];
	segi_div_t        head;

	logic             out_valid_q;
	segi_status_t     out_status_q;
	logic [T_W-1:0]   out_t_q;
	segi_div_t        last;

	assign en        = !out_valid_q || res_ready;
	assign pop_ready = en;
	assign res_valid = out_valid_q;
	assign status    = out_status_q;
	assign t_frac    = out_t_q;
	assign last      = div_s[T_FRAC_BITS-1];

	always_comb begin
		head.status = pop_data.status;
		head.t_one  = pop_data.t_one;
		head.den    = pop_data.den;
		head.rem    = pop_data.tn;
		head.quo    = '0;
		for (int j = 0; j < T_FRAC_BITS; j++) begin
			step[j] = segi_div_step((j == 0) ? head : div_s[(j == 0) ? 0 : j - 1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < T_FRAC_BITS; j++) begin
				v_s[j] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= pop_valid;
			for (int j = 1; j < T_FRAC_BITS; j++) begin
				v_s[j] <= v_s[j-1];
			end
			out_valid_q <= v_s[T_FRAC_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < T_FRAC_BITS; j++) begin
				div_s[j] <= step[j];
			end
			out_status_q <= last.status;
			if (last.status != ST_CROSS) begin
				out_t_q <= '0;
			end else if (last.t_one) begin
				out_t_q <= T_ONE;
			end else begin
				out_t_q <= {1'b0, last.quo};
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/segment_intersection.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// segment_intersection
// exact fixed-point crossing test of two 2-D segments with position along p
// ---------------------------------------------------------------------------
// One transaction carries two segments, p_start..p_end and q_start..q_end, as
// signed coordinates with 8 fraction bits. The block takes one transaction
// per clock while seg_ready is high and returns one result per transaction,
// in order. A front pipeline of five stages forms the edge vectors, the six
// exact 33x33 products, the cross products and the classification; a
// four-entry queue then feeds a back pipeline with one restoring divider
// stage per fraction bit of t (16) and a result register. status is 0 when
// the segments cross (endpoint touches included), 1 when they are parallel
// or degenerate and 2 when the lines cross outside the segments; t_frac is t
// with 16 fraction bits, truncated toward zero, exactly 65536 for t = 1 and
// 0 unless crossing.
// ---------------------------------------------------------------------------
module segment_intersection
	import segi_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// segment pair transaction
	input  wire logic                          seg_valid,
	output logic                               seg_ready,
	input  wire logic signed [COORD_WIDTH-1:0] p_start_x,
	input  wire logic signed [COORD_WIDTH-1:0] p_start_y,
	input  wire logic signed [COORD_WIDTH-1:0] p_end_x,
	input  wire logic signed [COORD_WIDTH-1:0] p_end_y,
	input  wire logic signed [COORD_WIDTH-1:0] q_start_x,
	input  wire logic signed [COORD_WIDTH-1:0] q_start_y,
	input  wire logic signed [COORD_WIDTH-1:0] q_end_x,
	input  wire logic signed [COORD_WIDTH-1:0] q_end_y,
	// result transaction
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output logic [1:0]                         status,
	output logic [T_W-1:0]                     t_frac
);

	// front to queue
	logic        push_valid, push_ready;
	segi_entry_t push_data;
	// queue to back
	logic        pop_valid, pop_ready;
	segi_entry_t pop_data;

	// products, cross terms and classification
	segi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg_valid  (seg_valid),
		.seg_ready  (seg_ready),
		.p_start_x  (p_start_x),
		.p_start_y  (p_start_y),
		.p_end_x    (p_end_x),
		.p_end_y    (p_end_y),
		.q_start_x  (q_start_x),
		.q_start_y  (q_start_y),
		.q_end_x    (q_end_x),
		.q_end_y    (q_end_y),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouples the two pipelines so each can stall on its own
	segi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// t = tn / den one bit per stage, then the result register
	segi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.status    (status),
		.t_frac    (t_frac)
	);

endmodule
`default_nettype wire

@@ verif/tb_segment_intersection.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_segment_intersection
// self-checking regression of the fixed-point segment crossing block
// ---------------------------------------------------------------------------
// A table of directed segment pairs runs first: degenerate and parallel
// pairs, endpoint touches at t and u of 0 and 1, pairs that miss, and
// coordinates at the ends of the signed range. Then come random pairs:
// full-range noise, small clustered segments, pairs built to cross at
// a known fraction along p, built parallel pairs and corner-value pairs.
// Every accepted transaction is predicted with exact wide arithmetic
// and each result is compared in order against the oldest prediction.
// Both channels idle at random, with one stretch of back-to-back traffic
// and one point where the sender drains the block before going on.
// ---------------------------------------------------------------------------
module tb_segment_intersection
	import segi_pkg::*;
();

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// one segment pair transaction
	typedef struct packed {
		coord_t psx;
		coord_t psy;
		coord_t pex;
		coord_t pey;
		coord_t qsx;
		coord_t qsy;
		coord_t qex;
		coord_t qey;
	} seg_pair_t;

	// one result transaction
	typedef struct packed {
		segi_status_t   status;
		logic [T_W-1:0] t_frac;
	} crossing_t;

	// directed row: typed-in result used only where fixed is set
	typedef struct packed {
		seg_pair_t pair;
		logic      fixed;
		crossing_t want;
	} stim_row_t;

	localparam coord_t CMAX = coord_t'(32'h7fff_ffff);
	localparam coord_t CMIN = coord_t'(32'h8000_0000);
	localparam int RANDOM_PAIRS  = 1650;
	localparam int DRAIN_AT      = 800;
	localparam int QUIET_FROM    = 1000;
	localparam int QUIET_TO      = 1300;
	localparam int IDLE_PCT      = 28;
	localparam int SETTLE_CYCLES = 50;

	localparam crossing_t PARALLEL = '{ST_PARALLEL, '0};
	localparam crossing_t OUTSIDE  = '{ST_OUTSIDE, '0};
	localparam crossing_t NO_WANT  = '{ST_CROSS, '0};

	logic           clk;
	logic           arst_n;
	logic           seg_valid;
	logic           seg_ready;
	coord_t         p_start_x;
	coord_t         p_start_y;
	coord_t         p_end_x;
	coord_t         p_end_y;
	coord_t         q_start_x;
	coord_t         q_start_y;
	coord_t         q_end_x;
	coord_t         q_end_y;
	logic           res_valid;
	logic           res_ready;
	logic [1:0]     status;
	logic [T_W-1:0] t_frac;

	// predictions waiting for their result, oldest first
	crossing_t expected_crossings[$];
	stim_row_t directed_rows[$];
	int        errors = 0;
	logic      quiet_stretch;

	segment_intersection dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_ready (seg_ready),
		.p_start_x (p_start_x),
		.p_start_y (p_start_y),
		.p_end_x   (p_end_x),
		.p_end_y   (p_end_y),
		.q_start_x (q_start_x),
		.q_start_y (q_start_y),
		.q_end_x   (q_end_x),
		.q_end_y   (q_end_y),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.status    (status),
		.t_frac    (t_frac)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// exact crossing test: every difference and cross product is held at
	// the full cross width, so no coordinate pattern can overflow
	function automatic crossing_t predict_crossing(seg_pair_t s);
		logic signed [CROSS_W-1:0]       p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
		logic signed [CROSS_W-1:0]       rx, ry, sx, sy, dx, dy, den, tn, un;
		logic [CROSS_W+T_FRAC_BITS-1:0] num, quo;
		crossing_t                       r;
		p1x = s.psx; p1y = s.psy; p2x = s.pex; p2y = s.pey;
		q1x = s.qsx; q1y = s.qsy; q2x = s.qex; q2y = s.qey;
		rx  = p2x - p1x;
		ry  = p2y - p1y;
		sx  = q2x - q1x;
		sy  = q2y - q1y;
		dx  = q1x - p1x;
		dy  = q1y - p1y;
		den = rx * sy - ry * sx;
		r   = PARALLEL;
		if (den == 0)
			return r;
		tn = dx * sy - dy * sx;
		un = dx * ry - dy * rx;
		// fold the sign of the denominator into the numerators
		if (den < 0) begin
			den = -den;
			tn  = -tn;
			un  = -un;
		end
		r = OUTSIDE;
		if (tn < 0 || un < 0 || tn > den || un > den)
			return r;
		// truncating division gives exactly one at tn == den
		num        = {tn, {T_FRAC_BITS{1'b0}}};
		quo        = num / {{T_FRAC_BITS{1'b0}}, den};
		r.status   = ST_CROSS;
		r.t_frac   = quo[T_W-1:0];
		return r;
	endfunction

	// signed value in [-2^bits, 2^bits)
	function automatic coord_t rand_span(int bits);
		coord_t v;
		v = coord_t'($urandom);
		return v >>> (COORD_WIDTH - 1 - bits);
	endfunction

	function automatic coord_t rand_corner();
		case ($urandom_range(5))
			0: return CMIN;
			1: return CMAX;
			2: return coord_t'(0);
			3: return coord_t'(-1);
			4: return coord_t'(1);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic seg_pair_t make_random_pair();
		seg_pair_t s;
		coord_t    rx, ry, mx, my;
		int        kind, bits, k, m;
		kind = $urandom_range(99);
		bits = $urandom_range(20, 2);
		if (kind < 35) begin
			// full-range noise
			s = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
		end else if (kind < 55) begin
			// short segments clustered near the origin, often crossing
			s.psx = rand_span(bits); s.psy = rand_span(bits);
			s.pex = rand_span(bits); s.pey = rand_span(bits);
			s.qsx = rand_span(bits); s.qsy = rand_span(bits);
			s.qex = rand_span(bits); s.qey = rand_span(bits);
		end else if (kind < 80) begin
			// q mirrored through a point k/8 along p: crosses at u = 1/2
			// unless parallel, k = 0 and k = 8 touch the endpoints of p
			s.psx = rand_span(26);
			s.psy = rand_span(26);
			rx    = rand_span(23) <<< 3;
			ry    = rand_span(23) <<< 3;
			s.pex = s.psx + rx;
			s.pey = s.psy + ry;
			k     = $urandom_range(8);
			mx    = s.psx + (rx >>> 3) * k;
			my    = s.psy + (ry >>> 3) * k;
			s.qsx = rand_span(26);
			s.qsy = rand_span(26);
			s.qex = 2 * mx - s.qsx;
			s.qey = 2 * my - s.qsy;
			if ($urandom_range(1)) begin
				{s.psx, s.pex} = {s.pex, s.psx};
				{s.psy, s.pey} = {s.pey, s.psy};
			end
		end else if (kind < 92) begin
			// q along a multiple of the direction of p, zero included
			s.psx = rand_span(24); s.psy = rand_span(24);
			rx    = rand_span(bits);
			ry    = rand_span(bits);
			m     = $urandom_range(4) - 2;
			s.pex = s.psx + rx; s.pey = s.psy + ry;
			s.qsx = rand_span(24); s.qsy = rand_span(24);
			s.qex = s.qsx + rx * m;
			s.qey = s.qsy + ry * m;
		end else begin
			s.psx = rand_corner(); s.psy = rand_corner();
			s.pex = rand_corner(); s.pey = rand_corner();
			s.qsx = rand_corner(); s.qsy = rand_corner();
			s.qex = rand_corner(); s.qey = rand_corner();
		end
		return s;
	endfunction

	// present one transaction, hold it until taken, then log its result
	task automatic send_pair(seg_pair_t s, crossing_t want);
		seg_valid <= 1'b1;
		p_start_x <= s.psx;
		p_start_y <= s.psy;
		p_end_x   <= s.pex;
		p_end_y   <= s.pey;
		q_start_x <= s.qsx;
		q_start_y <= s.qsy;
		q_end_x   <= s.qex;
		q_end_y   <= s.qey;
		@(posedge clk);
		while (!seg_ready)
			@(posedge clk);
		expected_crossings.push_back(want);
	endtask

	// random sender gap after an accepted transaction
	task automatic sender_gap(logic quiet);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			seg_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		seg_valid <= 1'b0;
		while (expected_crossings.size() != 0)
			@(posedge clk);
	endtask

	// directed table: degenerate, parallel, touches, misses, range ends
	initial begin
		// all coordinates equal: zero-length segments
		directed_rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, PARALLEL});
		directed_rows.push_back('{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX},
			1'b1, PARALLEL});
		directed_rows.push_back('{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN},
			1'b1, PARALLEL});
		// p along x from 0 to 2 m, q vertical at various x
		directed_rows.push_back('{'{0, 0, 512, 0, 256, -256, 256, 256},
			1'b1, '{ST_CROSS, T_ONE >> 1}});
		// touch at the start of p
		directed_rows.push_back('{'{0, 0, 512, 0, 0, -256, 0, 256},
			1'b1, '{ST_CROSS, '0}});
		// touch at the end of p
		directed_rows.push_back('{'{0, 0, 512, 0, 512, -256, 512, 256},
			1'b1, '{ST_CROSS, T_ONE}});
		// touch at the start and at the end of q
		directed_rows.push_back('{'{0, 0, 512, 0, 256, 0, 256, 256},
			1'b1, '{ST_CROSS, T_ONE >> 1}});
		directed_rows.push_back('{'{0, 0, 512, 0, 256, -256, 256, 0},
			1'b1, '{ST_CROSS, T_ONE >> 1}});
		// reversed p: negative denominator, touch at t = 1
		directed_rows.push_back('{'{512, 0, 0, 0, 0, -256, 0, 256},
			1'b1, '{ST_CROSS, T_ONE}});
		// lines cross beyond either end of p, and before the start of q
		directed_rows.push_back('{'{0, 0, 512, 0, 1024, -256, 1024, 256}, 1'b1, OUTSIDE});
		directed_rows.push_back('{'{0, 0, 512, 0, -256, -256, -256, 256}, 1'b1, OUTSIDE});
		directed_rows.push_back('{'{0, 0, 512, 0, 256, 256, 256, 512}, 1'b1, OUTSIDE});
		// collinear and offset parallel
		directed_rows.push_back('{'{0, 0, 512, 0, 0, 0, 512, 0}, 1'b1, PARALLEL});
		directed_rows.push_back('{'{0, 0, 512, 0, 0, 256, -512, 256}, 1'b1, PARALLEL});
		// zero-length p against a real q
		directed_rows.push_back('{'{5, 5, 5, 5, 0, 0, 512, 512}, 1'b1, PARALLEL});
		// identical full-range diagonals
		directed_rows.push_back('{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX},
			1'b1, PARALLEL});
		// full-range diagonals and axes crossing near the middle; tiny pair at opposite corners
		directed_rows.push_back('{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN},
			1'b0, NO_WANT});
		directed_rows.push_back('{'{CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX},
			1'b0, NO_WANT});
		directed_rows.push_back('{'{CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX}, 1'b0, NO_WANT});
		directed_rows.push_back('{'{CMIN, CMIN, CMIN + 1, CMIN, CMAX, CMAX, CMAX, CMAX - 1},
			1'b0, NO_WANT});
		// smallest and largest fractions below one
		directed_rows.push_back('{'{0, 0, CMAX, 0, 1, -1, 1, 1}, 1'b0, NO_WANT});
		directed_rows.push_back('{'{0, 0, CMAX, 0, CMAX - 1, -1, CMAX - 1, 1},
			1'b0, NO_WANT});
		directed_rows.push_back('{'{-7, 3, 1201, -944, 300, -500, -20, 77}, 1'b0, NO_WANT});
	end

	// receiver: check every result transaction, stall at random
	always @(posedge clk) begin
		crossing_t exp_r;
		if (arst_n && res_valid && res_ready) begin
			if (expected_crossings.size() == 0) begin
				$display("%0t: result with none expected, status %0d t_frac %0d",
					$time, status, t_frac);
				errors++;
			end else begin
				exp_r = expected_crossings.pop_front();
				if (status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, exp_r.status, status);
					errors++;
				end
				if (t_frac !== exp_r.t_frac) begin
					$display("%0t: t_frac expected %0d actual %0d",
						$time, exp_r.t_frac, t_frac);
					errors++;
				end
			end
		end
		res_ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
	end

	// sender: reset, directed table, random pairs, then drain and judge
	initial begin
		seg_pair_t s;
		arst_n        <= 1'b0;
		seg_valid     <= 1'b0;
		quiet_stretch <= 1'b0;
		p_start_x     <= '0;
		p_start_y     <= '0;
		p_end_x       <= '0;
		p_end_y       <= '0;
		q_start_x     <= '0;
		q_start_y     <= '0;
		q_end_x       <= '0;
		q_end_y       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_pair(directed_rows[i].pair, directed_rows[i].fixed ?
				directed_rows[i].want : predict_crossing(directed_rows[i].pair));
			sender_gap(1'b0);
		end

		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			// let the pipeline empty once before going on
			if (n == DRAIN_AT)
				wait_drained();
			if (n == QUIET_FROM)
				quiet_stretch <= 1'b1;
			if (n == QUIET_TO)
				quiet_stretch <= 1'b0;
			s = make_random_pair();
			send_pair(s, predict_crossing(s));
			sender_gap(n >= QUIET_FROM && n < QUIET_TO);
		end

		wait_drained();
		// watch for stray results after the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("segment_intersection regression: pass");
		else
			$display("segment_intersection regression: fail");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("segment_intersection regression: fail");
		$finish;
	end

endmodule
